// ----- hdl/lppd_pkg.sv -----
`timescale 1ns / 1ps

package lppd_pkg;

    localparam int SESS_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;
    localparam int HCNT_W  = 3;

    localparam logic [HCNT_W-1:0]  HDR_BYTES   = 3'd5;
    localparam logic [HCNT_W-1:0]  HDR_SIZE_LO = 3'd0;
    localparam logic [HCNT_W-1:0]  HDR_SIZE_HI = 3'd1;
    localparam logic [HCNT_W-1:0]  HDR_ID_LO   = 3'd2;
    localparam logic [HCNT_W-1:0]  HDR_ID_HI   = 3'd3;
    localparam logic [FIELD_W-1:0] MAX_BODY_RESET = 16'd1024;

    typedef enum logic {
        OP_BYTE  = 1'b0,
        OP_RESET = 1'b1
    } t_op;

    typedef enum logic {
        ST_OK       = 1'b0,
        ST_OVERSIZE = 1'b1
    } t_status;

    typedef struct packed {
        logic [HCNT_W-1:0]  hdr_cnt;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] left;
        logic               locked;
    } t_sess_state;

    typedef struct packed {
        logic [SESS_W-1:0]  session;
        logic [FIELD_W-1:0] pkt_id;
        logic [FIELD_W-1:0] body_length;
        logic [BYTE_W-1:0]  body_byte;
        logic               carries_data;
        logic               last;
        t_status            status;
    } t_result;

    typedef struct packed {
        t_sess_state next;
        logic        res_valid;
        t_result     res;
    } t_upd;

endpackage

// ----- hdl/lppd_update.sv -----
`timescale 1ns / 1ps

module lppd_update (
    input  lppd_pkg::t_sess_state          i_state,
    input  lppd_pkg::t_op                  i_op,
    input  logic [lppd_pkg::SESS_W-1:0]    i_session,
    input  logic [lppd_pkg::BYTE_W-1:0]    i_byte,
    input  logic [lppd_pkg::FIELD_W-1:0]   i_max_body,
    output lppd_pkg::t_upd                 o_upd
);

    logic [lppd_pkg::FIELD_W-1:0] n_size;
    logic [lppd_pkg::FIELD_W-1:0] n_id;
    logic [lppd_pkg::HCNT_W-1:0]  hc_inc;
    logic [lppd_pkg::FIELD_W-1:0] body;
    logic                         body_last;

    always_comb begin
        n_size = i_state.size;
        n_id   = i_state.id;
        case (i_state.hdr_cnt)
            lppd_pkg::HDR_SIZE_LO: n_size = {i_state.size[15:8], i_byte};
            lppd_pkg::HDR_SIZE_HI: n_size = {i_byte, i_state.size[7:0]};
            lppd_pkg::HDR_ID_LO:   n_id   = {i_state.id[15:8], i_byte};
            lppd_pkg::HDR_ID_HI:   n_id   = {i_byte, i_state.id[7:0]};
            default: ;
        endcase
        hc_inc = i_state.hdr_cnt + 3'd1;
        body   = (n_size >= lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES)) ?
                 n_size - lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES) : '0;
        body_last = (i_state.left <= 16'd1);

        o_upd                  = '0;
        o_upd.next             = i_state;
        o_upd.res.session      = i_session;
        o_upd.res.pkt_id       = i_state.id;
        o_upd.res.status       = lppd_pkg::ST_OK;

        if (i_op == lppd_pkg::OP_RESET) begin
            o_upd.next = '0;
        end else if (i_state.locked) begin
            o_upd.next = i_state;
        end else if (i_state.hdr_cnt < lppd_pkg::HDR_BYTES) begin
            o_upd.next.size = n_size;
            o_upd.next.id   = n_id;
            if (hc_inc < lppd_pkg::HDR_BYTES) begin
                o_upd.next.hdr_cnt = hc_inc;
            end else if (body > i_max_body) begin
                o_upd.next.locked    = 1'b1;
                o_upd.next.hdr_cnt   = '0;
                o_upd.next.left      = '0;
                o_upd.res_valid      = 1'b1;
                o_upd.res.pkt_id     = n_id;
                o_upd.res.body_length = body;
                o_upd.res.last       = 1'b1;
                o_upd.res.status     = lppd_pkg::ST_OVERSIZE;
            end else if (body == '0) begin
                o_upd.next.hdr_cnt  = '0;
                o_upd.next.left     = '0;
                o_upd.res_valid     = 1'b1;
                o_upd.res.pkt_id    = n_id;
                o_upd.res.last      = 1'b1;
            end else begin
                o_upd.next.hdr_cnt = lppd_pkg::HDR_BYTES;
                o_upd.next.left    = body;
            end
        end else begin
            o_upd.res_valid        = 1'b1;
            o_upd.res.body_length  = body;
            o_upd.res.body_byte    = i_byte;
            o_upd.res.carries_data = 1'b1;
            o_upd.res.last         = body_last;
            if (body_last) begin
                o_upd.next.left    = '0;
                o_upd.next.hdr_cnt = '0;
            end else begin
                o_upd.next.left = i_state.left - 16'd1;
            end
        end
    end

endmodule

// ----- hdl/length_prefixed_packet_deframer.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls or the RAM is clearing;
// same-session items back to back are forwarded. Each result passes the state RAM read,
// then the update into the output register.
// Reset: synchronous, active low; max_body_bytes returns to 1024 and a clearing pass
// zeroes the session RAM, one entry per cycle, with input not ready until it is done.
// Config writes are taken at any time, including during the clearing pass.

module length_prefixed_packet_deframer #(
    parameter int SESSIONS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,    // max_body_bytes
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata, // session_index[5:0], rx_byte[13:6], zero pad
    input  logic        i_s_axis_tuser, // operation
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata, // out_session[5:0], pkt_id[21:6],
                                        // body_length[37:22], body_byte[45:38], zero pad
    output logic [1:0]  o_m_axis_tuser, // carries_data[0], status[1]
    output logic        o_m_axis_tlast  // last
);

    localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int SW = $bits(lppd_pkg::t_sess_state);

    logic [SW-1:0] r_mem [SESSIONS];

    logic                         r_clearing;
    logic [AW-1:0]                r_clr_addr;
    logic [lppd_pkg::FIELD_W-1:0] r_max_body;

    logic                         r_s1_valid;
    logic                         r_s1_hit;
    logic [AW-1:0]                r_s1_addr;
    lppd_pkg::t_op                r_s1_op;
    logic [lppd_pkg::SESS_W-1:0]  r_s1_sess;
    logic [lppd_pkg::BYTE_W-1:0]  r_s1_byte;
    logic                         r_s1_fwd;
    logic [SW-1:0]                r_rd_data;
    logic [SW-1:0]                r_fwd_data;

    logic                         r_out_valid;
    lppd_pkg::t_result            r_out;

    logic [lppd_pkg::SESS_W-1:0]  in_sess;
    logic [lppd_pkg::BYTE_W-1:0]  in_byte;
    logic                         in_hit;
    logic [AW-1:0]                in_addr;
    logic                         in_xfer;
    logic                         out_free;
    logic                         s1_fire;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [SW-1:0]                wr_data;
    lppd_pkg::t_sess_state        s1_state;
    lppd_pkg::t_upd               upd;

    assign in_sess = i_s_axis_tdata[5:0];
    assign in_byte = i_s_axis_tdata[13:6];
    assign in_hit  = (32'(in_sess) < SESSIONS);
    assign in_addr = AW'(32'(in_sess));

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_clearing && (!r_s1_valid || out_free);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign s1_state = lppd_pkg::t_sess_state'(r_s1_fwd ? r_fwd_data : r_rd_data);

    lppd_update u_update (
        .i_state    (s1_state),
        .i_op       (r_s1_op),
        .i_session  (r_s1_sess),
        .i_byte     (r_s1_byte),
        .i_max_body (r_max_body),
        .o_upd      (upd)
    );

    assign wr_en   = r_clearing || (s1_fire && r_s1_hit);
    assign wr_addr = r_clearing ? r_clr_addr : r_s1_addr;
    assign wr_data = r_clearing ? '0 : SW'(upd.next);

    // state RAM
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (in_xfer && in_hit) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_data <= wr_data;
        end
        if (in_xfer) begin
            r_s1_hit  <= in_hit;
            r_s1_addr <= in_addr;
            r_s1_op   <= lppd_pkg::t_op'(i_s_axis_tuser);
            r_s1_sess <= in_sess;
            r_s1_byte <= in_byte;
            r_s1_fwd  <= wr_en && (wr_addr == in_addr);
        end
        if (s1_fire && r_s1_hit && upd.res_valid) begin
            r_out <= upd.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_max_body  <= lppd_pkg::MAX_BODY_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(SESSIONS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_max_body <= i_cfg_data;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1_hit && upd.res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.body_byte, r_out.body_length,
                              r_out.pkt_id, r_out.session};
    assign o_m_axis_tuser  = {r_out.status, r_out.carries_data};
    assign o_m_axis_tlast  = r_out.last;

endmodule

// ----- test/length_prefixed_packet_deframer_tb.sv -----
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_tb;

    typedef struct packed {
        lppd_pkg::t_op               op;
        logic [lppd_pkg::SESS_W-1:0] sess;
        logic [lppd_pkg::BYTE_W-1:0] data;
    } t_rx_item;

    class deframe_checker;
        logic [lppd_pkg::HCNT_W-1:0]  hdr_cnt   [64];
        logic [lppd_pkg::FIELD_W-1:0] size_f    [64];
        logic [lppd_pkg::FIELD_W-1:0] id_f      [64];
        logic [lppd_pkg::FIELD_W-1:0] left_f    [64];
        bit                           locked_st [64];
        logic [lppd_pkg::FIELD_W-1:0] max_body;
        lppd_pkg::t_result            pending_results [$];
        int                           taken_cnt;

        function new();
            for (int s = 0; s < 64; s++) begin
                clear_session(s);
            end
            max_body  = lppd_pkg::MAX_BODY_RESET;
            taken_cnt = 0;
        endfunction

        function void clear_session(int s);
            hdr_cnt[s]   = '0;
            size_f[s]    = '0;
            id_f[s]      = '0;
            left_f[s]    = '0;
            locked_st[s] = 1'b0;
        endfunction

        function logic [lppd_pkg::FIELD_W-1:0] body_of(int s);
            return (size_f[s] >= lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES)) ?
                   size_f[s] - lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES) : '0;
        endfunction

        function void queue_result(int s, logic [lppd_pkg::FIELD_W-1:0] len,
                                   logic [lppd_pkg::BYTE_W-1:0] b,
                                   logic data, logic fin, lppd_pkg::t_status st);
            lppd_pkg::t_result r;
            r.session      = s[lppd_pkg::SESS_W-1:0];
            r.pkt_id       = id_f[s];
            r.body_length  = len;
            r.body_byte    = b;
            r.carries_data = data;
            r.last         = fin;
            r.status       = st;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void note_input(lppd_pkg::t_op op, logic [lppd_pkg::SESS_W-1:0] s,
                                 logic [lppd_pkg::BYTE_W-1:0] b);
            logic [lppd_pkg::HCNT_W-1:0]  nxt;
            logic [lppd_pkg::FIELD_W-1:0] body;
            int                           si;
            si = int'(s);
            if (op == lppd_pkg::OP_RESET) begin
                clear_session(si);
                taken_cnt++;
                return;
            end
            if (locked_st[si]) begin
                return;
            end
            taken_cnt++;
            if (hdr_cnt[si] < lppd_pkg::HDR_BYTES) begin
                case (hdr_cnt[si])
                    lppd_pkg::HDR_SIZE_LO: size_f[si][7:0]  = b;
                    lppd_pkg::HDR_SIZE_HI: size_f[si][15:8] = b;
                    lppd_pkg::HDR_ID_LO:   id_f[si][7:0]    = b;
                    lppd_pkg::HDR_ID_HI:   id_f[si][15:8]   = b;
                    default: ;
                endcase
                nxt = hdr_cnt[si] + 1'b1;
                if (nxt < lppd_pkg::HDR_BYTES) begin
                    hdr_cnt[si] = nxt;
                    return;
                end
                body        = body_of(si);
                hdr_cnt[si] = '0;
                left_f[si]  = '0;
                if (body > max_body) begin
                    locked_st[si] = 1'b1;
                    queue_result(si, body, '0, 1'b0, 1'b1, lppd_pkg::ST_OVERSIZE);
                end else if (body == 0) begin
                    queue_result(si, '0, '0, 1'b0, 1'b1, lppd_pkg::ST_OK);
                end else begin
                    hdr_cnt[si] = lppd_pkg::HDR_BYTES;
                    left_f[si]  = body;
                end
            end else begin
                queue_result(si, body_of(si), b, 1'b1, left_f[si] <= 1, lppd_pkg::ST_OK);
                if (left_f[si] <= 1) begin
                    left_f[si]  = '0;
                    hdr_cnt[si] = '0;
                end else begin
                    left_f[si] = left_f[si] - 1'b1;
                end
            end
        endfunction

        function string check_result(lppd_pkg::t_result got);
            lppd_pkg::t_result want;
            string             d;
            d = "";
            if (pending_results.size() == 0) begin
                return $sformatf("unexpected result: session %0d id %h len %0d",
                                 got.session, got.pkt_id, got.body_length);
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.session != want.session)
                d = {d, $sformatf(" session %0d/%0d", got.session, want.session)};
            if (got.pkt_id != want.pkt_id)
                d = {d, $sformatf(" id %h/%h", got.pkt_id, want.pkt_id)};
            if (got.body_length != want.body_length)
                d = {d, $sformatf(" len %0d/%0d", got.body_length, want.body_length)};
            if (got.body_byte != want.body_byte)
                d = {d, $sformatf(" byte %h/%h", got.body_byte, want.body_byte)};
            if (got.carries_data != want.carries_data)
                d = {d, $sformatf(" data %b/%b", got.carries_data, want.carries_data)};
            if (got.last != want.last)
                d = {d, $sformatf(" last %b/%b", got.last, want.last)};
            if (got.status != want.status)
                d = {d, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (d != "")
                d = {"result mismatch (got/exp):", d};
            return d;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // session_index[5:0], rx_byte[13:6], zero pad
    logic        i_s_axis_tuser = 1'b0; // operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;      // out_session[5:0], pkt_id[21:6],
                                      // body_length[37:22], body_byte[45:38], zero pad
    logic [1:0]  o_m_axis_tuser;      // carries_data[0], status[1]
    logic        o_m_axis_tlast;

    deframe_checker sb = new();
    t_rx_item       burst_q [$];
    int             mismatch_count = 0;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    bit             hold_req = 1'b0;
    bit             hold_done = 1'b0;
    int             hold_left = 0;

    length_prefixed_packet_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // receiver: random ready, plus one long hold-off to back up the pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_mon
        lppd_pkg::t_result got;
        string             msg;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.session      = o_m_axis_tdata[5:0];
            got.pkt_id       = o_m_axis_tdata[21:6];
            got.body_length  = o_m_axis_tdata[37:22];
            got.body_byte    = o_m_axis_tdata[45:38];
            got.carries_data = o_m_axis_tuser[0];
            got.last         = o_m_axis_tlast;
            got.status       = lppd_pkg::t_status'(o_m_axis_tuser[1]);
            msg = sb.check_result(got);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    function automatic logic [lppd_pkg::BYTE_W-1:0] rand_byte();
        return lppd_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic void push_item(lppd_pkg::t_op op, logic [lppd_pkg::SESS_W-1:0] s,
                                      logic [lppd_pkg::BYTE_W-1:0] b);
        t_rx_item it;
        it.op   = op;
        it.sess = s;
        it.data = b;
        burst_q.insert(burst_q.size(), it);
    endfunction

    // one packet for session s, possibly with a short total; oversize ones get up to two dropped bytes and a reset
    function automatic void add_packet(logic [lppd_pkg::SESS_W-1:0] s,
                                       logic [lppd_pkg::FIELD_W-1:0] lim);
        int                           kind;
        int                           body;
        int                           cap;
        bit                           too_big;
        logic [lppd_pkg::FIELD_W-1:0] total;
        kind    = $urandom_range(0, 99);
        too_big = 1'b0;
        if (sb.hdr_cnt[s] != 0 || sb.locked_st[s] || kind < 4)
            push_item(lppd_pkg::OP_RESET, s, rand_byte());
        if (kind < 14 && lim < 16'd65530) begin
            body = (kind < 7) ? 65530 : int'(lim) + 1 + int'($urandom_range(0, 20));
            if (body > 65530)
                body = 65530;
            total   = lppd_pkg::FIELD_W'(body) + lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES);
            too_big = 1'b1;
        end else if (kind < 24) begin
            total = lppd_pkg::FIELD_W'($urandom_range(0, int'(lppd_pkg::HDR_BYTES)));
        end else begin
            cap  = ($urandom_range(0, 49) == 0) ? 300 : ($urandom_range(0, 4) == 0) ? 40 : 6;
            body = int'($urandom_range(0, (int'(lim) < cap) ? int'(lim) : cap));
            total = lppd_pkg::FIELD_W'(body) + lppd_pkg::FIELD_W'(lppd_pkg::HDR_BYTES);
        end
        push_item(lppd_pkg::OP_BYTE, s, total[7:0]);
        push_item(lppd_pkg::OP_BYTE, s, total[15:8]);
        repeat (3) push_item(lppd_pkg::OP_BYTE, s, rand_byte());
        if (too_big) begin
            repeat ($urandom_range(0, 2)) push_item(lppd_pkg::OP_BYTE, s, rand_byte());
            push_item(lppd_pkg::OP_RESET, s, rand_byte());
        end else if (total > lppd_pkg::HDR_BYTES) begin
            repeat (total - lppd_pkg::HDR_BYTES) push_item(lppd_pkg::OP_BYTE, s, rand_byte());
        end
    endfunction

    function automatic void build_burst();
        int       pos;
        t_rx_item tmp;
        burst_q.delete();
        repeat ($urandom_range(1, 4)) begin
            add_packet(lppd_pkg::SESS_W'(($urandom_range(0, 2) == 0) ?
                                         $urandom_range(0, 63) : $urandom_range(60, 63)),
                       sb.max_body);
        end
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                tmp.op   = ($urandom_range(0, 4) == 0) ? lppd_pkg::OP_RESET : lppd_pkg::OP_BYTE;
                tmp.sess = lppd_pkg::SESS_W'($urandom_range(0, 63));
                tmp.data = rand_byte();
                burst_q.insert($urandom_range(0, burst_q.size()), tmp);
            end
        end
        // interleave sessions, keeping each session's own order
        if (burst_q.size() >= 2) begin
            repeat (2 * burst_q.size()) begin
                pos = $urandom_range(0, burst_q.size() - 2);
                if (burst_q[pos].sess != burst_q[pos+1].sess) begin
                    tmp            = burst_q[pos];
                    burst_q[pos]   = burst_q[pos+1];
                    burst_q[pos+1] = tmp;
                end
            end
        end
    endfunction

    task automatic send_item(t_rx_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, it.data, it.sess};
        i_s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(it.op, it.sess, it.data);
    endtask

    task automatic run_burst();
        foreach (burst_q[i]) send_item(burst_q[i]);
    endtask

    // stop sending and let every expected result come out, then let the pipe empty
    task automatic settle();
        int n;
        n = 0;
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_body(logic [lppd_pkg::FIELD_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.max_body = v;
    endtask

    initial begin
        logic [lppd_pkg::FIELD_W-1:0] lim_vals [6];
        int                           start_cnt;
        bit                           paused;
        lim_vals = '{16'd7, 16'd0, 16'hFFFF, 16'd0, 16'd2, 16'd300};
        lim_vals[3] = lppd_pkg::FIELD_W'($urandom_range(0, 65535));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: header-only, short total, one-byte body, oversize lock and unlock
        tx_idle_pct = 29;
        rx_idle_pct = 72;
        burst_q.delete();
        push_item(lppd_pkg::OP_BYTE, 6'd0, 8'h05);
        push_item(lppd_pkg::OP_BYTE, 6'd0, 8'h00);
        push_item(lppd_pkg::OP_BYTE, 6'd0, 8'h34);
        push_item(lppd_pkg::OP_BYTE, 6'd0, 8'h12);
        push_item(lppd_pkg::OP_BYTE, 6'd0, 8'hAA);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h03);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h00);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h06);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h00);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h00);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'h00);
        push_item(lppd_pkg::OP_BYTE, 6'd63, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'h01);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'h80);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'h7F);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'h55);
        push_item(lppd_pkg::OP_RESET, 6'd1, 8'hFF);
        push_item(lppd_pkg::OP_BYTE, 6'd1, 8'h05);
        run_burst();

        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 72 : 0;
            rx_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 29 : 0;
            write_max_body(lim_vals[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            start_cnt = sb.taken_cnt;
            paused    = 1'b0;
            while (sb.taken_cnt - start_cnt < 90) begin
                build_burst();
                run_burst();
                if (ph == 4 && !paused && sb.taken_cnt - start_cnt >= 50) begin
                    paused = 1'b1;
                    settle();
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.pending_results.size()));
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
